@@ sv/etssr_pkg.sv @@
// Shared types, constants and helper functions for the echo range display block.
`timescale 1ns / 1ps

package etssr_pkg;

   // Input transfer: echo width in half-microsecond ticks and unit select
   typedef struct packed {
      logic [15:0] echo_ticks;
      logic        unit_inches;
   } req_type;

   // Result transfer: four segment codes and the error flag
   typedef struct packed {
      logic [7:0] seg_pos0;
      logic [7:0] seg_pos1;
      logic [7:0] seg_pos2;
      logic [7:0] seg_pos3;
      logic       out_of_range;
   } rsp_type;

   // Distance in tenths, at most 9999
   typedef logic [13:0] n_type;

   // Front to queue push
   typedef struct packed {
      logic  valid;
      n_type n;
   } qpush_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstatus_type;

   // One decimal digit and what remains below it
   typedef struct packed {
      logic [3:0] digit;
      n_type      rem;
   } split_type;

   // ticks * 8575 / 100000 = (ticks * 343 / 32) / 125
   // ticks * 8575 / 254000 = (ticks * 343 / 16) / 635
   localparam logic [8:0]  TICK_SCALE  = 9'd343;
   localparam logic [9:0]  DIV_CM      = 10'd125;
   localparam logic [9:0]  DIV_IN      = 10'd635;
   localparam int          RECIP_SHIFT = 27;
   localparam logic [20:0] RECIP_CM    = 21'((64'd1 << RECIP_SHIFT) / 64'd125);
   localparam logic [20:0] RECIP_IN    = 21'((64'd1 << RECIP_SHIFT) / 64'd635);
   localparam n_type       N_MAX       = 14'd9999;

   localparam logic [7:0] SEG_E  = 8'h79;
   localparam logic [7:0] SEG_DP = 8'h80;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [9:0] W_THOUSANDS = 10'd1000;
   localparam logic [9:0] W_HUNDREDS  = 10'd100;
   localparam logic [9:0] W_TENS      = 10'd10;

   // Map a decimal digit to its segment code, bit0 a to bit6 g
   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] code;
      unique case (d)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7F;
         4'd9: code = 8'h6F;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // Peel off one digit of weight w by parallel threshold compares;
   // x must stay below 10 * w
   function automatic split_type digit_split(input n_type x, input logic [9:0] w);
      split_type res;
      n_type     wide_w;
      wide_w    = {4'd0, w};
      res.digit = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (x >= n_type'(14'(k) * wide_w)) begin
            res.digit = 4'(k);
         end
      end
      res.rem = x - n_type'({10'd0, res.digit} * wide_w);
      return res;
   endfunction

endpackage

@@ sv/etssr_front.sv @@
// Front pipeline: accept echo widths and convert them to tenths of the chosen unit.
`timescale 1ns / 1ps

module etssr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  etssr_pkg::req_type    req_data,
   input  etssr_pkg::qstatus_type q_status,
   output etssr_pkg::qpush_type  q_push
);
   import etssr_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [24:0] s1_prod_ff, s1_prod_in;
   logic        s1_unit_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [20:0] s2_x_ff, s2_x_in;
   logic [41:0] s2_m_ff, s2_m_in;
   logic        s2_unit_ff;
   logic        s3_valid_ff, s3_valid_in;
   n_type       s3_n_ff, s3_n_in;

   logic        ready1, ready2, ready3;
   logic [14:0] q_est;
   logic [14:0] q_fix;
   logic [24:0] q_times_d;
   logic [24:0] rem;
   logic [9:0]  divisor;

   // Advance each stage when it is empty or the next one moves
   assign ready3   = !s3_valid_ff || !q_status.full;
   assign ready2   = !s2_valid_ff || ready3;
   assign ready1   = !s1_valid_ff || ready2;
   assign req_full = !ready1;

   assign s1_valid_in = ready1 ? req_push : s1_valid_ff;
   assign s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = ready3 ? s2_valid_ff : s3_valid_ff;

   // Scale ticks by 343
   assign s1_prod_in = {9'd0, req_data.echo_ticks} * {16'd0, TICK_SCALE};

   // Drop the power-of-two part of the divisor, multiply by the reciprocal
   always_comb begin
      s2_x_in = s1_unit_ff ? s1_prod_ff[24:4] : {1'b0, s1_prod_ff[24:5]};
      s2_m_in = {21'd0, s2_x_in} * {21'd0, (s1_unit_ff ? RECIP_IN : RECIP_CM)};
   end

   // Correct the estimate by one compare, then clamp
   always_comb begin
      divisor   = s2_unit_ff ? DIV_IN : DIV_CM;
      q_est     = s2_m_ff[41:RECIP_SHIFT];
      q_times_d = {10'd0, q_est} * {15'd0, divisor};
      rem       = {4'd0, s2_x_ff} - q_times_d;
      q_fix     = (rem >= {15'd0, divisor}) ? q_est + 15'd1 : q_est;
      s3_n_in   = (q_fix > {1'b0, N_MAX}) ? N_MAX : q_fix[13:0];
   end

   assign q_push.valid = s3_valid_ff && !q_status.full;
   assign q_push.n     = s3_n_ff;

   // Hold valid bits under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Load payload as stages advance
   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_prod_ff <= s1_prod_in;
         s1_unit_ff <= req_data.unit_inches;
      end
      if (ready2) begin
         s2_x_ff    <= s2_x_in;
         s2_m_ff    <= s2_m_in;
         s2_unit_ff <= s1_unit_ff;
      end
      if (ready3) begin
         s3_n_ff <= s3_n_in;
      end
   end

endmodule

@@ sv/etssr_queue.sv @@
// Short queue of distances between the front and back pipelines.
`timescale 1ns / 1ps

module etssr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  etssr_pkg::qpush_type   q_push,
   input  logic                   q_pop,
   output etssr_pkg::qstatus_type q_status,
   output etssr_pkg::n_type       head_n
);
   import etssr_pkg::*;

   n_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign q_status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_pop         = q_pop && !q_status.empty;
   assign head_n         = mem_ff[rd_ptr_ff];

   // Advance pointers and count per transfer
   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QPTR_W{1'b0}}, q_push.valid}
                           - {{QPTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the pushed entry
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         mem_ff[wr_ptr_ff] <= q_push.n;
      end
   end

endmodule

@@ sv/etssr_back.sv @@
// Back pipeline: split distances into digits and build the segment pattern.
`timescale 1ns / 1ps

module etssr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  etssr_pkg::qstatus_type q_status,
   input  etssr_pkg::n_type       head_n,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output etssr_pkg::rsp_type     rsp_data
);
   import etssr_pkg::*;

   logic       b1_valid_ff, b1_valid_in;
   logic [3:0] b1_d3_ff;
   n_type      b1_rem_ff;
   logic       b2_valid_ff, b2_valid_in;
   logic [3:0] b2_d3_ff, b2_d2_ff;
   n_type      b2_rem_ff;
   logic       b3_valid_ff, b3_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic      ready1, ready2, ready3;
   split_type sp3, sp2, sp1;
   logic      err;

   // Advance each stage when empty or the next one moves
   assign ready3 = !b3_valid_ff || rsp_pop;
   assign ready2 = !b2_valid_ff || ready3;
   assign ready1 = !b1_valid_ff || ready2;
   assign q_pop  = ready1 && !q_status.empty;

   assign b1_valid_in = ready1 ? !q_status.empty : b1_valid_ff;
   assign b2_valid_in = ready2 ? b1_valid_ff : b2_valid_ff;
   assign b3_valid_in = ready3 ? b2_valid_ff : b3_valid_ff;

   assign sp3 = digit_split(head_n, W_THOUSANDS);
   assign sp2 = digit_split(b1_rem_ff, W_HUNDREDS);
   assign sp1 = digit_split(b2_rem_ff, W_TENS);

   // Encode digits, blank leading zeros, substitute EE when out of range
   always_comb begin
      err = ((b2_d3_ff == 4'd0) && (b2_d2_ff == 4'd0) && (sp1.digit <= 4'd2))
            || (b2_d3_ff >= 4'd4);
      rsp_in.seg_pos0     = seg_code(sp1.rem[3:0]);
      rsp_in.seg_pos1     = seg_code(sp1.digit) | SEG_DP;
      rsp_in.seg_pos2     = seg_code(b2_d2_ff);
      rsp_in.seg_pos3     = seg_code(b2_d3_ff);
      rsp_in.out_of_range = err;
      if (b2_d3_ff == 4'd0) begin
         rsp_in.seg_pos3 = 8'h00;
         if (b2_d2_ff == 4'd0) begin
            rsp_in.seg_pos2 = 8'h00;
         end
      end
      if (err) begin
         rsp_in.seg_pos0 = SEG_E;
         rsp_in.seg_pos1 = SEG_E | SEG_DP;
         rsp_in.seg_pos2 = 8'h00;
         rsp_in.seg_pos3 = 8'h00;
      end
   end

   assign rsp_empty = !b3_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
         b3_valid_ff <= b3_valid_in;
      end
   end

   // Load payload as stages advance
   always_ff @(posedge clock) begin
      if (ready1) begin
         b1_d3_ff  <= sp3.digit;
         b1_rem_ff <= sp3.rem;
      end
      if (ready2) begin
         b2_d3_ff  <= b1_d3_ff;
         b2_d2_ff  <= sp2.digit;
         b2_rem_ff <= sp2.rem;
      end
      if (ready3) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ sv/echo_to_seven_segment_range.sv @@
// Echo width to four-position seven-segment range readout, top level.
// A result reaches the rsp_ ports through three conversion stages, one queue entry, two digit
// stages and the output register, the first conversion stage loaded at the edge of its req_
// transfer.
// Throughput: one item per cycle unless rsp_pop stalls, set by the fully pipelined front and back.
// Stalls on the result side fill the four-entry queue before req_full rises.
// Synchronous reset empties every stage and the queue; no result is pending.
`timescale 1ns / 1ps

module echo_to_seven_segment_range (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  etssr_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output etssr_pkg::rsp_type rsp_data
);
   import etssr_pkg::*;

   qpush_type   q_push;
   qstatus_type q_status;
   n_type       head_n;
   logic        q_pop;

   // Convert echo width to tenths
   etssr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_status (q_status),
      .q_push   (q_push)
   );

   // Decouple front and back
   etssr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status),
      .head_n   (head_n)
   );

   // Build the display pattern
   etssr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_n    (head_n),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push.valid)
      else $error("push into full queue");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !q_pop)
      else $error("pop from empty queue");

   // Reset leaves no result pending and input open
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("pipeline not empty after reset");

   // Error pattern always blanks the upper positions and shows E in the lowest
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_of_range) |->
         (rsp_data.seg_pos2 == 8'h00 && rsp_data.seg_pos3 == 8'h00
          && rsp_data.seg_pos0 == SEG_E))
      else $error("bad error pattern");

endmodule

@@ bench/echo_to_seven_segment_range_tb.sv @@
// Self-checking testbench for the echo range seven-segment readout block.
`timescale 1ns / 1ps

module echo_to_seven_segment_range_tb;
   import etssr_pkg::*;

   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned SETTLE_TIME  = 24;
   localparam int unsigned RANDOM_ITEMS = 1500;
   localparam int unsigned REPORT_MAX   = 10;

   // One pending echo; hold_for_idle makes the sender wait for every result first
   typedef struct {
      req_type echo;
      bit      hold_for_idle;
   } echo_item_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_data  = '0;
   logic    rsp_pop   = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   echo_item_type echo_queue[$];
   rsp_type       expected_readouts[$];

   logic [7:0] digit_segments [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                        8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
   int unsigned near_marks [0:5] = '{350, 889, 1167, 11662, 29621, 46648};

   bit          req_fire    = 1'b0;
   bit          rsp_fire    = 1'b0;
   int unsigned send_gap    = 0;
   int unsigned pop_gap     = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned readouts_checked = 0;
   int unsigned error_readouts = 0;
   int unsigned inch_readouts = 0;

   echo_to_seven_segment_range DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Predict the display pattern for one echo width
   function automatic rsp_type readout_for(input req_type echo);
      logic [31:0] scaled;
      logic [31:0] tenths;
      logic [3:0]  d0, d1, d2, d3;
      rsp_type     shown;
      scaled = 32'(echo.echo_ticks) * 32'd8575;
      tenths = echo.unit_inches ? scaled / 32'd254000 : scaled / 32'd100000;
      if (tenths > 32'd9999) begin
         tenths = 32'd9999;
      end
      d0 = 4'(tenths % 10);
      d1 = 4'((tenths / 10) % 10);
      d2 = 4'((tenths / 100) % 10);
      d3 = 4'(tenths / 1000);
      shown.seg_pos0     = digit_segments[d0];
      shown.seg_pos1     = digit_segments[d1];
      shown.seg_pos2     = digit_segments[d2];
      shown.seg_pos3     = digit_segments[d3];
      shown.out_of_range = 1'b0;
      // blank leading zeros in the two upper positions
      if (d3 == 4'd0) begin
         shown.seg_pos3 = 8'h00;
         if (d2 == 4'd0) begin
            shown.seg_pos2 = 8'h00;
         end
      end
      // too near or too far: show EE
      if ((d3 == 4'd0 && d2 == 4'd0 && d1 <= 4'd2) || d3 >= 4'd4) begin
         shown.seg_pos0     = SEG_E;
         shown.seg_pos1     = SEG_E;
         shown.seg_pos2     = 8'h00;
         shown.seg_pos3     = 8'h00;
         shown.out_of_range = 1'b1;
      end
      shown.seg_pos1 = shown.seg_pos1 | SEG_DP;
      return shown;
   endfunction

   // Gap before the next transfer: mostly none or short, a few long
   function automatic int unsigned pick_gap(input int unsigned cycle);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if ((cycle / 400) % 4 == 0) begin
         return 0;
      end
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic add_echo(input int unsigned ticks, input bit inches, input bit hold);
      echo_item_type item;
      item.echo.echo_ticks  = 16'(ticks);
      item.echo.unit_inches = inches;
      item.hold_for_idle    = hold;
      echo_queue.push_back(item);
   endtask

   task automatic note_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what, want, got);
      end
   endtask

   // Drive the request side at the falling edge
   always @(negedge clock) begin
      int unsigned gap;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_fire) begin
            void'(echo_queue.pop_front());
         end
         if (!(req_push && !req_fire)) begin
            gap = req_fire ? pick_gap(cycle_count) : send_gap;
            if (gap != 0) begin
               req_push <= 1'b0;
               send_gap <= gap - 1;
            end else if (echo_queue.size() != 0 &&
                         (!echo_queue[0].hold_for_idle || expected_readouts.size() == 0)) begin
               req_push <= 1'b1;
               req_data <= echo_queue[0].echo;
               send_gap <= 0;
            end else begin
               req_push <= 1'b0;
               send_gap <= 0;
            end
         end
      end
   end

   // Drive the result side at the falling edge
   always @(negedge clock) begin
      int unsigned gap;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         gap = rsp_fire ? pick_gap(cycle_count + 200) : pop_gap;
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            pop_gap <= gap - 1;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap <= 0;
         end
      end
   end

   // Sample transfers at the rising edge, check results, watch for a stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fire    <= 1'b0;
         rsp_fire    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_push && !req_full;
         rsp_fire <= rsp_pop && !rsp_empty;
         if (rsp_pop && !rsp_empty) begin
            if (expected_readouts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("%0t: result with nothing expected: %h", $realtime, rsp_data);
               end
            end else begin
               want = expected_readouts.pop_front();
               if (want.seg_pos0 != rsp_data.seg_pos0)
                  note_mismatch("seg_pos0", want.seg_pos0, rsp_data.seg_pos0);
               if (want.seg_pos1 != rsp_data.seg_pos1)
                  note_mismatch("seg_pos1", want.seg_pos1, rsp_data.seg_pos1);
               if (want.seg_pos2 != rsp_data.seg_pos2)
                  note_mismatch("seg_pos2", want.seg_pos2, rsp_data.seg_pos2);
               if (want.seg_pos3 != rsp_data.seg_pos3)
                  note_mismatch("seg_pos3", want.seg_pos3, rsp_data.seg_pos3);
               if (want.out_of_range != rsp_data.out_of_range)
                  note_mismatch("out_of_range", 8'(want.out_of_range),
                                8'(rsp_data.out_of_range));
               readouts_checked++;
               if (want.out_of_range) begin
                  error_readouts++;
               end
            end
         end
         if (req_push && !req_full) begin
            expected_readouts.push_back(readout_for(req_data));
            if (req_data.unit_inches) begin
               inch_readouts++;
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("echo_to_seven_segment_range_tb failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Fill the stimulus, release reset, wait for the drain and report
   initial begin
      int unsigned roll;
      int unsigned ticks;
      // directed: extremes, range edges, blanking edges, alternating bits
      add_echo(0, 1'b0, 1'b0);
      add_echo(0, 1'b1, 1'b0);
      add_echo(65535, 1'b0, 1'b0);
      add_echo(65535, 1'b1, 1'b0);
      add_echo(1, 1'b0, 1'b0);
      add_echo(349, 1'b0, 1'b0);
      add_echo(350, 1'b0, 1'b0);
      add_echo(888, 1'b1, 1'b0);
      add_echo(889, 1'b1, 1'b0);
      add_echo(1166, 1'b0, 1'b0);
      add_echo(1167, 1'b0, 1'b0);
      add_echo(11661, 1'b0, 1'b0);
      add_echo(11662, 1'b0, 1'b0);
      add_echo(29620, 1'b1, 1'b0);
      add_echo(29621, 1'b1, 1'b0);
      add_echo(46647, 1'b0, 1'b0);
      add_echo(46648, 1'b0, 1'b0);
      add_echo(16'hAAAA, 1'b1, 1'b0);
      add_echo(16'h5555, 1'b0, 1'b0);
      add_echo(16'h5555, 1'b1, 1'b0);
      add_echo(3000, 1'b0, 1'b0);
      add_echo(12345, 1'b1, 1'b0);
      // random: full range, the useful span, and near the display edges
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            ticks = $urandom_range(0, 65535);
         end else if (roll < 75) begin
            ticks = $urandom_range(0, 47000);
         end else begin
            ticks = near_marks[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3;
         end
         add_echo(ticks, $urandom_range(0, 1), i == 0 || i == RANDOM_ITEMS / 2);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (echo_queue.size() != 0 || expected_readouts.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TIME) @(posedge clock);

      $display("checked %0d readouts, %0d in inches, %0d showing the range error",
               readouts_checked, inch_readouts, error_readouts);
      $display("mismatches: %0d, results still expected: %0d",
               mismatch_count, expected_readouts.size());
      if (mismatch_count == 0 && expected_readouts.size() == 0) begin
         $display("echo_to_seven_segment_range_tb passed");
      end else begin
         $display("echo_to_seven_segment_range_tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/etssr_pkg.sv
sv/etssr_front.sv
sv/etssr_queue.sv
sv/etssr_back.sv
sv/echo_to_seven_segment_range.sv
bench/echo_to_seven_segment_range_tb.sv
